// ===== hdl/gchlp_pkg.sv =====
// ----------------------------------------------------------------------------
// gchlp_pkg
// Shared types and constants for the group-count hash table with linear
// probing between buckets.
// ----------------------------------------------------------------------------
package gchlp_pkg;

   localparam int BKT_W       = 3;
   localparam int LANE_W      = 4;
   localparam int NUM_BUCKETS = 1 << BKT_W;
   localparam int LANES       = 1 << LANE_W;
   localparam int KEY_W       = 32;
   localparam int CNT_W       = 32;

   localparam logic [CNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      ST_UPDATED  = 2'd0,
      ST_INSERTED = 2'd1,
      ST_FULL     = 2'd2,
      ST_ZERO     = 2'd3
   } status_type;

   typedef logic [LANES-1:0][KEY_W-1:0] key_row_type;
   typedef logic [LANES-1:0][CNT_W-1:0] cnt_row_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic rd;
      logic eval;
      logic reject;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic key_zero;
      logic found;
      logic last_try;
   } dp_sts_type;

endpackage

// ===== hdl/gchlp_dpath.sv =====
// ----------------------------------------------------------------------------
// gchlp_dpath
// Bucket store, lane compare, count update and result registers.
// ----------------------------------------------------------------------------
module gchlp_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  gchlp_pkg::ctl_cmd_type          cmd,
   output gchlp_pkg::dp_sts_type           sts,
   input  logic [gchlp_pkg::KEY_W-1:0]     req_key,
   input  logic                            req_last_item,
   output logic [gchlp_pkg::CNT_W-1:0]     rsp_new_count,
   output logic [1:0]                      rsp_status,
   output logic [gchlp_pkg::BKT_W-1:0]     rsp_bucket,
   output logic [gchlp_pkg::LANE_W-1:0]    rsp_lane,
   output logic                            rsp_last_item_res
);
   import gchlp_pkg::*;

   key_row_type             key_mem [NUM_BUCKETS];
   cnt_row_type             cnt_mem [NUM_BUCKETS];
   logic [NUM_BUCKETS-1:0]  row_valid_ff;

   logic [KEY_W-1:0]        key_ff;
   logic                    last_ff;
   logic [BKT_W-1:0]        bkt_ff;
   logic [BKT_W-1:0]        tries_ff;
   key_row_type             key_row_ff;
   cnt_row_type             cnt_row_ff;

   logic [CNT_W-1:0]        count_ff;
   status_type              status_ff;
   logic [BKT_W-1:0]        bucket_ff;
   logic [LANE_W-1:0]       lane_ff;
   logic                    last_res_ff;

   logic [LANES-1:0]        hit_vec;
   logic [LANES-1:0]        free_vec;
   logic                    any_hit;
   logic                    any_free;
   logic [LANE_W-1:0]       hit_ln;
   logic [LANE_W-1:0]       free_ln;
   logic [LANE_W-1:0]       wr_ln;
   logic [CNT_W-1:0]        cur_cnt;
   logic [CNT_W-1:0]        inc_cnt;
   logic                    last_try;
   logic                    wr_en;
   key_row_type             key_row_in;
   cnt_row_type             cnt_row_in;
   logic [CNT_W-1:0]        count_in;
   status_type              status_in;
   logic [BKT_W-1:0]        bucket_in;
   logic [LANE_W-1:0]       lane_in;

   // lane compare and lowest-index select
   always_comb begin
      hit_ln  = '0;
      free_ln = '0;
      for (int i = 0; i < LANES; i++) begin
         hit_vec[i]  = (key_row_ff[i] == key_ff);
         free_vec[i] = (key_row_ff[i] == '0);
      end
      for (int i = LANES - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_ln = LANE_W'(i);
         end
         if (free_vec[i]) begin
            free_ln = LANE_W'(i);
         end
      end
   end

   assign any_hit  = |hit_vec;
   assign any_free = |free_vec;
   assign last_try = (tries_ff == BKT_W'(NUM_BUCKETS - 1));
   assign cur_cnt  = cnt_row_ff[hit_ln];
   assign inc_cnt  = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + CNT_W'(1);
   assign wr_ln    = any_hit ? hit_ln : free_ln;
   assign wr_en    = cmd.eval && (any_hit || any_free);

   always_comb begin
      key_row_in = key_row_ff;
      cnt_row_in = cnt_row_ff;
      key_row_in[wr_ln] = key_ff;
      cnt_row_in[wr_ln] = any_hit ? inc_cnt : CNT_W'(1);
   end

   always_comb begin
      if (any_hit) begin
         count_in  = inc_cnt;
         status_in = ST_UPDATED;
         bucket_in = bkt_ff;
         lane_in   = hit_ln;
      end else if (any_free) begin
         count_in  = CNT_W'(1);
         status_in = ST_INSERTED;
         bucket_in = bkt_ff;
         lane_in   = free_ln;
      end else begin
         count_in  = '0;
         status_in = ST_FULL;
         bucket_in = '0;
         lane_in   = '0;
      end
   end

   assign sts.key_zero = (key_ff == '0);
   assign sts.found    = any_hit || any_free;
   assign sts.last_try = last_try;

   // bucket store: one row read or written per cycle
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         key_row_ff <= row_valid_ff[bkt_ff] ? key_mem[bkt_ff] : '0;
         cnt_row_ff <= row_valid_ff[bkt_ff] ? cnt_mem[bkt_ff] : '0;
      end
      if (wr_en) begin
         key_mem[bkt_ff] <= key_row_in;
         cnt_mem[bkt_ff] <= cnt_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (wr_en) begin
         row_valid_ff[bkt_ff] <= 1'b1;
      end
   end

   // probe position and captured item
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff   <= req_key;
         last_ff  <= req_last_item;
         bkt_ff   <= req_key[BKT_W-1:0];
         tries_ff <= '0;
      end else if (cmd.eval && !(any_hit || any_free)) begin
         // advance to the next bucket, wrapping
         bkt_ff   <= bkt_ff + BKT_W'(1);
         tries_ff <= tries_ff + BKT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.reject) begin
         count_ff    <= '0;
         status_ff   <= ST_ZERO;
         bucket_ff   <= '0;
         lane_ff     <= '0;
         last_res_ff <= last_ff;
      end else if (cmd.eval) begin
         count_ff    <= count_in;
         status_ff   <= status_in;
         bucket_ff   <= bucket_in;
         lane_ff     <= lane_in;
         last_res_ff <= last_ff;
      end
   end

   assign rsp_new_count     = count_ff;
   assign rsp_status        = status_ff;
   assign rsp_bucket        = bucket_ff;
   assign rsp_lane          = lane_ff;
   assign rsp_last_item_res = last_res_ff;

endmodule

// ===== hdl/gchlp_ctrl.sv =====
// ----------------------------------------------------------------------------
// gchlp_ctrl
// Sequencer for the probe loop: read a bucket, evaluate it, finish or move on.
// ----------------------------------------------------------------------------
module gchlp_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   output logic                     rsp_valid,
   output gchlp_pkg::ctl_cmd_type   cmd,
   input  gchlp_pkg::dp_sts_type    sts
);
   import gchlp_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_EVAL
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      rsp_valid_ff;

   always_comb begin
      cmd.load   = (state_ff == S_IDLE) && start;
      cmd.rd     = (state_ff == S_READ) && !sts.key_zero;
      cmd.reject = (state_ff == S_READ) && sts.key_zero;
      cmd.eval   = (state_ff == S_EVAL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  state_ff <= S_READ;
                  busy_ff  <= 1'b1;
               end
            end
            S_READ: begin
               if (sts.key_zero) begin
                  state_ff     <= S_IDLE;
                  busy_ff      <= 1'b0;
                  rsp_valid_ff <= 1'b1;
               end else begin
                  state_ff <= S_EVAL;
               end
            end
            S_EVAL: begin
               if (sts.found || sts.last_try) begin
                  state_ff     <= S_IDLE;
                  busy_ff      <= 1'b0;
                  rsp_valid_ff <= 1'b1;
               end else begin
                  state_ff <= S_READ;
               end
            end
            default: begin
               state_ff <= S_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/group_count_hash_linear_probe_core.sv =====
// ----------------------------------------------------------------------------
// group_count_hash_linear_probe_core
// Counts occurrences of 32-bit keys in a bucketed hash table, probing
// linearly from the home bucket.
// ----------------------------------------------------------------------------
// Each probe is one row read and one row evaluate/write of the single-port
// bucket store; up to 8 buckets are probed (1 for a home-bucket hit), and a
// zero key is rejected without a probe. A new item is taken only when idle.
// Reset clears all row valid bits at once, so the table reads empty at once.
// Results are strobed for one cycle; the receiver cannot stall.
module group_count_hash_linear_probe_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [gchlp_pkg::KEY_W-1:0]     req_key,
   input  logic                            req_last_item,
   output logic                            rsp_valid,
   output logic [gchlp_pkg::CNT_W-1:0]     rsp_new_count,
   output logic [1:0]                      rsp_status,
   output logic [gchlp_pkg::BKT_W-1:0]     rsp_bucket,
   output logic [gchlp_pkg::LANE_W-1:0]    rsp_lane,
   output logic                            rsp_last_item_res
);
   import gchlp_pkg::*;

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   gchlp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   gchlp_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_key           (req_key),
      .req_last_item     (req_last_item),
      .rsp_new_count     (rsp_new_count),
      .rsp_status        (rsp_status),
      .rsp_bucket        (rsp_bucket),
      .rsp_lane          (rsp_lane),
      .rsp_last_item_res (rsp_last_item_res)
   );

endmodule

// ===== hdl/gchlp_checker.sv =====
// ----------------------------------------------------------------------------
// gchlp_checker
// Port-level checks on the group-count core, bound to the top level.
// ----------------------------------------------------------------------------
module gchlp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic [gchlp_pkg::KEY_W-1:0]     req_key,
   input logic                            req_last_item,
   input logic                            rsp_valid,
   input logic [gchlp_pkg::CNT_W-1:0]     rsp_new_count,
   input logic [1:0]                      rsp_status,
   input logic [gchlp_pkg::BKT_W-1:0]     rsp_bucket,
   input logic [gchlp_pkg::LANE_W-1:0]    rsp_lane,
   input logic                            rsp_last_item_res
);
   import gchlp_pkg::*;

   // a transfer in marks the block busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accepting an item");

   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobed while still busy");

   // a zero key is rejected on the shortest path
   a_zero_key: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_key == '0) |=> ##1
         rsp_valid && (rsp_status == ST_ZERO) && (rsp_last_item_res == $past(req_last_item, 2)))
      else $error("zero key not rejected in time");

   a_drop_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == ST_ZERO) || (rsp_status == ST_FULL)) |->
         (rsp_new_count == '0) && (rsp_bucket == '0) && (rsp_lane == '0))
      else $error("dropped key reports nonzero fields");

   a_insert_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_INSERTED) |-> (rsp_new_count == CNT_W'(1)))
      else $error("inserted key count is not one");

endmodule

bind group_count_hash_linear_probe_core gchlp_checker u_gchlp_checker (.*);
